### sv/lfpa_pkg.sv
// Shared types and constants for the lidar frame parser.
package lfpa_pkg;

  localparam logic [7:0] HEADER_BYTE     = 8'hAA;
  localparam logic [2:0] HEADER_LEN      = 3'd4;
  localparam int         BYTES_PER_POINT = 15;
  localparam int         SLOT_BITS       = BYTES_PER_POINT * 8;
  localparam int         QUEUE_DEPTH     = 4;
  localparam int         QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int         DIV_STEPS       = 32;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  localparam logic REC_POINT   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] addr;
    logic [7:0] data;
  } cmd_t;

endpackage

### sv/lidar_frame_parser_average.sv
// Lidar frame parser: one received byte per beat in, point and summary records out.
// Bytes are taken one per cycle while the four-entry command queue has room. Header,
// address, command, offset and length bytes cost nothing downstream; each payload byte
// is written by the back end into the single-port payload memory. The checksum byte
// starts frame emission: each point needs 15 memory reads, the return of the last byte
// and the presentation of its record, which waits while the result side stalls; then a
// bit-serial divide forms the average before the summary record. During emission the
// header and other non-payload bytes of the next frame pass freely; the queue absorbs
// four of its payload bytes before in_ready drops. The payload memory is not cleared at
// reset; every slot read is written earlier in the same frame.
module lidar_frame_parser_average #(
  parameter int PAYLOAD_BYTES    = 184,
  parameter int POINTS_PER_FRAME = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_record_kind,
  output logic [3:0]         out_point_index,
  output logic signed [15:0] out_distance,
  output logic [15:0]        out_noise,
  output logic [31:0]        out_peak,
  output logic [7:0]         out_confidence,
  output logic [31:0]        out_integration_time,
  output logic signed [15:0] out_reference_tof,
  output logic [15:0]        out_average_distance,
  output logic [3:0]         out_valid_points,
  output logic               out_last_of_frame
);
  import lfpa_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, q_full, q_pop, q_valid;

  lfpa_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_ready   (in_ready),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  lfpa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (pop_cmd)
  );

  lfpa_back #(
    .PAYLOAD_BYTES    (PAYLOAD_BYTES),
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_cmd                (pop_cmd),
    .q_pop                (q_pop),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_record_kind      (out_record_kind),
    .out_point_index      (out_point_index),
    .out_distance         (out_distance),
    .out_noise            (out_noise),
    .out_peak             (out_peak),
    .out_confidence       (out_confidence),
    .out_integration_time (out_integration_time),
    .out_reference_tof    (out_reference_tof),
    .out_average_distance (out_average_distance),
    .out_valid_points     (out_valid_points),
    .out_last_of_frame    (out_last_of_frame)
  );

  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_record_kind == out_last_of_frame))
    else $error("record kind and end-of-frame flag disagree");

  a_point_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == REC_POINT) |->
      (out_point_index < 4'(POINTS_PER_FRAME)) && (out_average_distance == 16'd0) &&
      (out_valid_points == 4'd0))
    else $error("point record carries summary fields or a bad index");

  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == REC_SUMMARY) |->
      (out_valid_points <= 4'(POINTS_PER_FRAME)) && (out_distance == 16'sd0) &&
      (out_point_index == 4'd0))
    else $error("summary record carries point fields or too many points");

endmodule

### sv/lfpa_front.sv
// Frame header hunter and phase tracker; issues store and emit commands.
module lfpa_front #(
  parameter int PAYLOAD_BYTES = 184
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [7:0]    in_rx_byte,
  output logic          in_ready,
  input  logic          q_full,
  output logic          push,
  output lfpa_pkg::cmd_t push_cmd
);
  import lfpa_pkg::*;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_ADDR    = 4'd1;
  localparam logic [3:0] PH_CMD     = 4'd2;
  localparam logic [3:0] PH_OFF1    = 4'd3;
  localparam logic [3:0] PH_OFF2    = 4'd4;
  localparam logic [3:0] PH_LENLO   = 4'd5;
  localparam logic [3:0] PH_LENHI   = 4'd6;
  localparam logic [3:0] PH_PAYLOAD = 4'd7;
  localparam logic [3:0] PH_CHECK   = 4'd8;

  localparam logic [7:0] PAY_LEN  = 8'(PAYLOAD_BYTES);
  localparam logic [7:0] PAY_LAST = 8'(PAYLOAD_BYTES - 1);

  logic [3:0] phase_r, phase_nxt;
  logic [2:0] run_r, run_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic       fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    pos_nxt   = pos_r;
    push      = 1'b0;
    push_cmd  = '{op: OP_STORE, addr: pos_r, data: in_rx_byte};
    if (fire) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (in_rx_byte == HEADER_BYTE) begin
            run_nxt = run_r + 3'd1;
            if (run_nxt == HEADER_LEN) phase_nxt = PH_ADDR;
          end else begin
            run_nxt = 3'd0;
          end
        end
        PH_ADDR, PH_CMD, PH_OFF1, PH_OFF2, PH_LENLO: begin
          phase_nxt = phase_r + 4'd1;
        end
        PH_LENHI: begin
          pos_nxt   = 8'd0;
          phase_nxt = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (pos_r < PAY_LEN) begin
            push    = 1'b1;
            pos_nxt = pos_r + 8'd1;
            if (pos_r == PAY_LAST) phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          push         = 1'b1;
          push_cmd.op  = OP_EMIT;
          phase_nxt    = PH_HEADER;
          run_nxt      = 3'd0;
        end
        default: begin
          phase_nxt = PH_HEADER;
          run_nxt   = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      run_r   <= 3'd0;
      pos_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

### sv/lfpa_queue.sv
// Short command queue between the parser front and the record back end.
module lfpa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lfpa_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output lfpa_pkg::cmd_t pop_cmd
);
  import lfpa_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = entry_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/lfpa_div.sv
// Bit-serial restoring divider, 32-bit dividend by 4-bit divisor.
module lfpa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [3:0]  divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import lfpa_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] step_r, step_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [3:0]    dvs_r, dvs_nxt;
  logic [4:0]    rem_sh;

  assign done     = done_r;
  assign quotient = q_r;
  assign rem_sh   = {rem_r, q_r[31]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = 4'd0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // one quotient bit a cycle, shifted in from the bottom
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = 4'(rem_sh - {1'b0, dvs_r});
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[3:0];
        q_nxt   = {q_r[30:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

### sv/lfpa_back.sv
// Payload store, point decoder, distance averaging and result register.
module lfpa_back #(
  parameter int PAYLOAD_BYTES    = 184,
  parameter int POINTS_PER_FRAME = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  lfpa_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_record_kind,
  output logic [3:0]          out_point_index,
  output logic signed [15:0]  out_distance,
  output logic [15:0]         out_noise,
  output logic [31:0]         out_peak,
  output logic [7:0]          out_confidence,
  output logic [31:0]         out_integration_time,
  output logic signed [15:0]  out_reference_tof,
  output logic [15:0]         out_average_distance,
  output logic [3:0]          out_valid_points,
  output logic                out_last_of_frame
);
  import lfpa_pkg::*;

  localparam int         AW        = $clog2(PAYLOAD_BYTES);
  localparam logic [3:0] LAST_PNT  = 4'(POINTS_PER_FRAME - 1);
  localparam logic [3:0] SLOT_LEN  = 4'(BYTES_PER_POINT);
  localparam logic [7:0] SLOT_STEP = 8'(BYTES_PER_POINT);

  localparam logic [2:0] B_IDLE   = 3'd0;
  localparam logic [2:0] B_READ   = 3'd1;
  localparam logic [2:0] B_PUT    = 3'd2;
  localparam logic [2:0] B_DSTART = 3'd3;
  localparam logic [2:0] B_DWAIT  = 3'd4;
  localparam logic [2:0] B_SUM    = 3'd5;

  logic [7:0] mem [PAYLOAD_BYTES];
  logic [7:0] rd_data_r;

  logic [2:0]           st_r, st_nxt;
  logic [7:0]           base_r, base_nxt;
  logic [3:0]           iss_r, iss_nxt;
  logic                 pend_r, pend_nxt;
  logic [SLOT_BITS-1:0] slot_r, slot_nxt;
  logic [3:0]           pnt_r, pnt_nxt;
  logic [31:0]          sum_r, sum_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic        mem_we, rd_en, out_free, load_pt, load_sum, div_start, div_done;
  logic [7:0]  rd_addr;
  logic [15:0] slot_dist;
  logic [31:0] quot;

  assign q_pop     = (st_r == B_IDLE) && q_valid;
  assign mem_we    = q_pop && (q_cmd.op == OP_STORE);
  assign rd_addr   = base_r + {4'd0, iss_r};
  assign out_free  = !out_valid_r || out_ready;
  assign slot_dist = slot_r[15:0];
  assign out_valid = out_valid_r;

  always_comb begin
    st_nxt    = st_r;
    base_nxt  = base_r;
    iss_nxt   = iss_r;
    pend_nxt  = 1'b0;
    slot_nxt  = slot_r;
    pnt_nxt   = pnt_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    load_pt   = 1'b0;
    load_sum  = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (q_pop && q_cmd.op == OP_EMIT) begin
          base_nxt = 8'd0;
          iss_nxt  = 4'd0;
          pnt_nxt  = 4'd0;
          sum_nxt  = 32'd0;
          cnt_nxt  = 4'd0;
          st_nxt   = B_READ;
        end
      end
      B_READ: begin
        if (iss_r != SLOT_LEN) begin
          rd_en    = 1'b1;
          iss_nxt  = iss_r + 4'd1;
          pend_nxt = 1'b1;
        end
        // shift each returned byte in from the top: byte 0 ends at the bottom
        if (pend_r) slot_nxt = {rd_data_r, slot_r[SLOT_BITS-1:8]};
        if (iss_r == SLOT_LEN && pend_r) st_nxt = B_PUT;
      end
      B_PUT: begin
        if (out_free) begin
          load_pt = 1'b1;
          if (slot_dist != 16'd0) begin
            sum_nxt = sum_r + {{16{slot_dist[15]}}, slot_dist};
            cnt_nxt = cnt_r + 4'd1;
          end
          if (pnt_r == LAST_PNT) begin
            st_nxt = B_DSTART;
          end else begin
            pnt_nxt  = pnt_r + 4'd1;
            base_nxt = base_r + SLOT_STEP;
            iss_nxt  = 4'd0;
            st_nxt   = B_READ;
          end
        end
      end
      B_DSTART: begin
        div_start = 1'b1;
        st_nxt    = B_DWAIT;
      end
      B_DWAIT: begin
        if (div_done) st_nxt = B_SUM;
      end
      B_SUM: begin
        if (out_free) begin
          load_sum = 1'b1;
          st_nxt   = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
    out_valid_nxt = (load_pt || load_sum) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_cmd.addr[AW-1:0]] <= q_cmd.data;
    if (rd_en) rd_data_r <= mem[rd_addr[AW-1:0]];
  end

  lfpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    iss_r  <= iss_nxt;
    slot_r <= slot_nxt;
    pnt_r  <= pnt_nxt;
    sum_r  <= sum_nxt;
    cnt_r  <= cnt_nxt;
    if (load_pt) begin
      out_record_kind      <= REC_POINT;
      out_point_index      <= pnt_r;
      out_distance         <= slot_r[15:0];
      out_noise            <= slot_r[31:16];
      out_peak             <= slot_r[63:32];
      out_confidence       <= slot_r[71:64];
      out_integration_time <= slot_r[103:72];
      out_reference_tof    <= slot_r[119:104];
      out_average_distance <= 16'd0;
      out_valid_points     <= 4'd0;
      out_last_of_frame    <= 1'b0;
    end else if (load_sum) begin
      out_record_kind      <= REC_SUMMARY;
      out_point_index      <= 4'd0;
      out_distance         <= 16'sd0;
      out_noise            <= 16'd0;
      out_peak             <= 32'd0;
      out_confidence       <= 8'd0;
      out_integration_time <= 32'd0;
      out_reference_tof    <= 16'sd0;
      out_average_distance <= (cnt_r == 4'd0) ? 16'd0 : quot[15:0];
      out_valid_points     <= cnt_r;
      out_last_of_frame    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
